// ===== hw/rtl/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// kps_pkg
// Types and constants shared by the keyframe position sampler.
// ----------------------------------------------------------------------------
package kps_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REST_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REST_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REST_Z = 3'd4;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [9:0] FRAME_RATE_RESET = 10'd30;

	// one frame in q16.16, added to every frame time
	localparam logic [42:0] ONE_Q16 = 43'd65536;

	typedef struct packed {
		logic               mode;
		logic [5:0]         key_slot;
		logic [30:0]        key_frame_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic signed [31:0] query_time;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               from_rest;
	} result_t;

	typedef struct packed {
		logic [30:0]        time_f;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} key_t;

	// clamp a 35-bit signed sum to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic [34:0] v);
		logic [31:0] r;
		if (!v[34] && (v[33:31] != 3'b000)) begin
			r = 32'h7fff_ffff;
		end else if (v[34] && (v[33:31] != 3'b111)) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/keyframe_position_sampler_top.sv =====
// ----------------------------------------------------------------------------
// keyframe_position_sampler_top
// Samples a 3D position track by linear interpolation between stored keys.
// ----------------------------------------------------------------------------
// A load item (mode 0) writes one key into the key store in the cycle it is
// taken and leaves busy low, so loads go at one per cycle while busy is low.
// A query item (mode 1) raises busy until its result is out: it scales the
// time to frames on the shared multiplier, streams the keys out of the key
// memory to find the bracket (at most MAX_KEYS active keys), runs a
// restoring division for the blend factor when two keys bracket the time,
// and then does the three blends and rest offsets on the same multiplier.
// A negative time or an empty track returns the rest position in the cycle
// after start, without raising busy. done is high for one cycle with the
// result on result; there is no back-pressure, so the receiver must take it
// then.
module keyframe_position_sampler_top #(
	parameter int MAX_KEYS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  kps_pkg::item_t                    item,
	output logic                              done,
	output kps_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [kps_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [kps_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import kps_pkg::*;

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int NW = $clog2(MAX_KEYS + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_FT   = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_MUL  = 6'b010000,
		ST_ACC  = 6'b100000
	} state_t;

	state_t state_q;

	logic [6:0]         key_count_q;
	logic [9:0]         frame_rate_q;
	logic signed [31:0] rest_x_q;
	logic signed [31:0] rest_y_q;
	logic signed [31:0] rest_z_q;

	key_t key_mem_q [MAX_KEYS];
	key_t rd_q;
	logic rd_vld_q;
	logic [NW-1:0] rd_idx_q;
	logic [NW-1:0] issue_q;

	key_t bef_q;
	key_t aft_q;
	logic signed [31:0] t_q;
	logic [31:0] rem_q;
	logic [30:0] den_q;
	logic [15:0] f_q;
	logic [3:0]  div_cnt_q;
	logic [1:0]  axis_q;
	logic signed [49:0] prod_q;

	logic done_q;
	result_t result_q;

	logic accept;
	logic [NW-1:0] n_w;
	logic [42:0] ft_w;
	logic [42:0] num_w;
	logic [31:0] rem2_w;
	logic ge_w;
	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_p;
	logic signed [31:0] sel_a;
	logic signed [31:0] sel_b;
	logic signed [31:0] sel_r;
	logic signed [32:0] diff_w;
	logic [34:0] sum_w;
	logic [31:0] sat_w;
	logic slot_ok;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done = done_q;
	assign result = result_q;

	always_comb begin
		if (32'(key_count_q) > 32'(MAX_KEYS)) begin
			n_w = NW'(MAX_KEYS);
		end else begin
			n_w = NW'(key_count_q);
		end
	end

	assign slot_ok = (32'(item.key_slot) < 32'(MAX_KEYS));

	// frame time, valid while scanning: product of the time and frame rate plus one frame
	assign ft_w = prod_q[42:0] + ONE_Q16;
	assign num_w = ft_w - {12'd0, bef_q.time_f};

	assign rem2_w = {rem_q[30:0], 1'b0};
	assign ge_w = (rem2_w >= {1'b0, den_q});

	always_comb begin
		case (axis_q)
			2'd0: begin
				sel_a = aft_q.x;
				sel_b = bef_q.x;
				sel_r = rest_x_q;
			end
			2'd1: begin
				sel_a = aft_q.y;
				sel_b = bef_q.y;
				sel_r = rest_y_q;
			end
			default: begin
				sel_a = aft_q.z;
				sel_b = bef_q.z;
				sel_r = rest_z_q;
			end
		endcase
	end

	assign diff_w = {sel_a[31], sel_a} - {sel_b[31], sel_b};

	// shared multiplier: time scaling, then one blend per axis
	always_comb begin
		if (state_q == ST_FT) begin
			mul_a = {1'b0, t_q};
			mul_b = {7'd0, frame_rate_q};
		end else begin
			mul_a = diff_w;
			mul_b = {1'b0, f_q};
		end
	end

	assign mul_p = mul_a * mul_b;

	// rest + before + floor(product / 65536)
	assign sum_w = {{3{sel_r[31]}}, sel_r} + {{3{sel_b[31]}}, sel_b}
		+ {prod_q[49], prod_q[49:16]};
	assign sat_w = sat32(sum_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			frame_rate_q <= FRAME_RATE_RESET;
			rest_x_q <= '0;
			rest_y_q <= '0;
			rest_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_KEY_COUNT: key_count_q <= cfg_data[6:0];
				CFG_FRAME_RATE: frame_rate_q <= cfg_data[9:0];
				CFG_REST_X: rest_x_q <= cfg_data;
				CFG_REST_Y: rest_y_q <= cfg_data;
				CFG_REST_Z: rest_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (item.mode == MODE_LOAD) && slot_ok) begin
			key_mem_q[AW'(item.key_slot)] <= '{
				time_f: item.key_frame_time,
				x: item.key_x,
				y: item.key_y,
				z: item.key_z
			};
		end
		rd_q <= key_mem_q[issue_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			rd_vld_q <= 1'b0;
			rd_idx_q <= '0;
			issue_q <= '0;
			div_cnt_q <= '0;
			axis_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.mode == MODE_QUERY)) begin
						if (item.query_time[31] || (n_w == '0)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_FT;
						end
					end
				end
				ST_FT: begin
					issue_q <= '0;
					rd_vld_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// one key issued per cycle, compared the cycle after
					rd_vld_q <= (issue_q < n_w);
					rd_idx_q <= issue_q;
					if (issue_q < n_w) begin
						issue_q <= issue_q + 1'b1;
					end
					if (rd_vld_q) begin
						if ({12'd0, rd_q.time_f} > ft_w) begin
							if (rd_idx_q == '0) begin
								axis_q <= '0;
								state_q <= ST_MUL;
							end else begin
								div_cnt_q <= '0;
								state_q <= ST_DIV;
							end
						end else if (rd_idx_q == n_w - 1'b1) begin
							axis_q <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 4'hf) begin
						axis_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					axis_q <= axis_q + 1'b1;
					if (axis_q == 2'd2) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && (item.mode == MODE_QUERY)) begin
					t_q <= item.query_time;
					result_q <= '{
						pos_x: rest_x_q,
						pos_y: rest_y_q,
						pos_z: rest_z_q,
						from_rest: 1'b1
					};
				end
			end
			ST_FT: begin
				prod_q <= mul_p;
			end
			ST_SCAN: begin
				if (rd_vld_q) begin
					if ({12'd0, rd_q.time_f} > ft_w) begin
						aft_q <= rd_q;
						f_q <= '0;
						if (rd_idx_q == '0) begin
							// before the track: hold the first key
							bef_q <= rd_q;
						end else begin
							rem_q <= {1'b0, num_w[30:0]};
							den_q <= rd_q.time_f - bef_q.time_f;
						end
					end else begin
						bef_q <= rd_q;
						if (rd_idx_q == n_w - 1'b1) begin
							// past the track: hold the last key
							aft_q <= rd_q;
							f_q <= '0;
						end
					end
				end
			end
			ST_DIV: begin
				rem_q <= ge_w ? (rem2_w - {1'b0, den_q}) : rem2_w;
				f_q <= {f_q[14:0], ge_w};
			end
			ST_MUL: begin
				prod_q <= mul_p;
			end
			ST_ACC: begin
				result_q.from_rest <= 1'b0;
				case (axis_q)
					2'd0: result_q.pos_x <= sat_w;
					2'd1: result_q.pos_y <= sat_w;
					default: result_q.pos_z <= sat_w;
				endcase
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a query is still in work");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < {1'b0, den_q}))
		else $error("division remainder not below divisor");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_q <= n_w))
		else $error("key scan ran past the key count");
`endif

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the keyframe position sampler against a cycle-free model of the
// track: key loads update a shadow key store, every query is predicted and
// compared field by field with the result taken on done. A short directed
// table covers the rest cases, saturation, holds at both ends, zero and
// maximum frame rates and out-of-order keys. Randomized phases follow, each
// with a fresh register setting and a freshly loaded ascending track.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import kps_pkg::*;

	localparam int KEY_SLOTS = 64;
	localparam int RANDOM_ITEMS = 800;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT = 500000;
	localparam longint FRAME_ONE = 64'sd65536;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		item_t                 it;
		logic                  fixed;
		result_t               want;
	} step_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	item_t                 item = '0;
	logic                  done;
	result_t               result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow copy of the registers and the key store
	logic [6:0]         trk_count = 7'd0;
	logic [9:0]         trk_rate = FRAME_RATE_RESET;
	logic signed [31:0] rest_x = '0;
	logic signed [31:0] rest_y = '0;
	logic signed [31:0] rest_z = '0;
	logic [30:0]        key_tm [KEY_SLOTS];
	logic signed [31:0] key_px [KEY_SLOTS];
	logic signed [31:0] key_py [KEY_SLOTS];
	logic signed [31:0] key_pz [KEY_SLOTS];

	result_t   pending_pos [$];
	step_row_t dir_rows [$];
	int        mismatches = 0;
	int        cycle_count = 0;
	bit        settled = 1'b1;
	bit        idle_on = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	keyframe_position_sampler_top #(
		.MAX_KEYS(KEY_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	function automatic logic [31:0] clamp32(input longint v);
		if (v > Q_MAX) return 32'h7fff_ffff;
		if (v < Q_MIN) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// b + floor((a - b) * frac / 2^16)
	function automatic longint lerp(input logic signed [31:0] b, input logic signed [31:0] a,
			input longint frac);
		longint p;
		p = (longint'(a) - longint'(b)) * frac;
		return longint'(b) + (p >>> 16);
	endfunction

	function automatic result_t sample_track(input logic signed [31:0] qt);
		result_t     r;
		int unsigned n, k, held;
		longint      ft, frac, px, py, pz;
		n = (trk_count > KEY_SLOTS) ? KEY_SLOTS : trk_count;
		r.from_rest = (qt < 0) || (n == 0);
		if (r.from_rest) begin
			r.pos_x = rest_x;
			r.pos_y = rest_y;
			r.pos_z = rest_z;
			return r;
		end
		ft = FRAME_ONE + longint'(qt) * longint'(trk_rate);
		k = 0;
		while (k < n && longint'(key_tm[k]) <= ft) k++;
		if (k == 0 || k == n) begin
			// outside the track: hold the nearest end key
			held = (k == 0) ? 0 : n - 1;
			px = key_px[held];
			py = key_py[held];
			pz = key_pz[held];
		end else begin
			frac = ((ft - longint'(key_tm[k-1])) << 16)
				/ (longint'(key_tm[k]) - longint'(key_tm[k-1]));
			px = lerp(key_px[k-1], key_px[k], frac);
			py = lerp(key_py[k-1], key_py[k], frac);
			pz = lerp(key_pz[k-1], key_pz[k], frac);
		end
		r.pos_x = clamp32(longint'(rest_x) + px);
		r.pos_y = clamp32(longint'(rest_y) + py);
		r.pos_z = clamp32(longint'(rest_z) + pz);
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 32'h1f_ffff)) - 32'h10_0000;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'hffff_ffff;
					default: return 32'h0;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// unused fields are filled at random, the block has to ignore them
	function automatic item_t load_item(input logic [5:0] slot, input logic [30:0] tm,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		item_t it;
		it.mode = MODE_LOAD;
		it.key_slot = slot;
		it.key_frame_time = tm;
		it.key_x = x;
		it.key_y = y;
		it.key_z = z;
		it.query_time = $urandom;
		return it;
	endfunction

	function automatic item_t query_item(input logic [31:0] qt);
		item_t it;
		it.mode = MODE_QUERY;
		it.key_slot = 6'($urandom);
		it.key_frame_time = 31'($urandom);
		it.key_x = $urandom;
		it.key_y = $urandom;
		it.key_z = $urandom;
		it.query_time = qt;
		return it;
	endfunction

	function automatic step_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		step_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	function automatic step_row_t item_row(input item_t it);
		step_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.it = it;
		return row;
	endfunction

	function automatic step_row_t fixed_row(input logic [31:0] qt, input result_t want);
		step_row_t row;
		row = item_row(query_item(qt));
		row.fixed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic void add_row(input step_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	// stop sending, let every pending result arrive and the block go quiet
	task automatic settle();
		if (!settled) begin
			start <= 1'b0;
			while (pending_pos.size() != 0) @(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
			settled = 1'b1;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_KEY_COUNT: trk_count = val[6:0];
			CFG_FRAME_RATE: trk_rate = val[9:0];
			CFG_REST_X: rest_x = val;
			CFG_REST_Y: rest_y = val;
			CFG_REST_Z: rest_z = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(input item_t it, input logic fixed, input result_t want);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		settled = 1'b0;
		if (it.mode == MODE_LOAD) begin
			key_tm[it.key_slot] = it.key_frame_time;
			key_px[it.key_slot] = it.key_x;
			key_py[it.key_slot] = it.key_y;
			key_pz[it.key_slot] = it.key_z;
		end else begin
			pending_pos.insert(pending_pos.size(),
				fixed ? want : sample_track(it.query_time));
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (done) begin
			if (pending_pos.size() == 0) begin
				$error("result with no query pending: %h", result);
				mismatches++;
			end else begin
				want = pending_pos.pop_front();
				if (result.pos_x !== want.pos_x) begin
					$error("pos_x expected %h got %h", want.pos_x, result.pos_x);
					mismatches++;
				end
				if (result.pos_y !== want.pos_y) begin
					$error("pos_y expected %h got %h", want.pos_y, result.pos_y);
					mismatches++;
				end
				if (result.pos_z !== want.pos_z) begin
					$error("pos_z expected %h got %h", want.pos_z, result.pos_z);
					mismatches++;
				end
				if (result.from_rest !== want.from_rest) begin
					$error("from_rest expected %b got %b", want.from_rest, result.from_rest);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : run
		int          phase, kc, fr, n_keys, nq, i, j, random_items;
		int unsigned smin, smax, spread;
		longint      tprev, aim, qt_l;
		logic [31:0] qt;

		// empty track, rest position and saturation of the rest offsets
		add_row(fixed_row(32'h0, result_t'{32'h0, 32'h0, 32'h0, 1'b1}));
		add_row(fixed_row(32'h7fff_ffff, result_t'{32'h0, 32'h0, 32'h0, 1'b1}));
		add_row(reg_row(CFG_REST_X, 32'h7fff_ffff));
		add_row(reg_row(CFG_REST_Y, 32'h8000_0000));
		add_row(reg_row(CFG_REST_Z, 32'h0001_8000));
		add_row(fixed_row(32'h8000_0000,
			result_t'{32'h7fff_ffff, 32'h8000_0000, 32'h0001_8000, 1'b1}));
		add_row(item_row(load_item(6'd0, 31'h2_0000, 32'h0010_0000,
			32'hfff0_0000, 32'h0)));
		add_row(item_row(load_item(6'd1, 31'h4_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h1)));
		add_row(item_row(load_item(6'd2, 31'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'hffff_ffff)));
		add_row(item_row(load_item(6'd63, 31'h0, 32'h5555_5555,
			32'haaaa_aaaa, 32'h1234_5678)));
		// default frame rate, query before the first key saturates against the rest
		add_row(reg_row(CFG_KEY_COUNT, 32'd3));
		add_row(fixed_row(32'h0,
			result_t'{32'h7fff_ffff, 32'h8000_0000, 32'h0001_8000, 1'b0}));
		add_row(reg_row(CFG_REST_X, 32'h0));
		add_row(reg_row(CFG_REST_Y, 32'h0));
		add_row(reg_row(CFG_REST_Z, 32'h0));
		add_row(item_row(query_item(32'h0000_0889)));
		add_row(item_row(query_item(32'h0000_1000)));
		add_row(item_row(query_item(32'h0000_2222)));
		add_row(fixed_row(32'h7fff_ffff,
			result_t'{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0}));
		// zero frame rate pins every query to frame one
		add_row(reg_row(CFG_FRAME_RATE, 32'd0));
		add_row(fixed_row(32'h7fff_ffff,
			result_t'{32'h0010_0000, 32'hfff0_0000, 32'h0, 1'b0}));
		add_row(reg_row(CFG_FRAME_RATE, 32'd1023));
		add_row(item_row(query_item(32'h0000_0040)));
		add_row(item_row(query_item(32'h0000_0041)));
		// keys out of order
		add_row(item_row(load_item(6'd1, 31'h1_0000, 32'h0003_0000,
			32'hfffd_0000, 32'h7fff_ffff)));
		add_row(item_row(query_item(32'h0000_0041)));
		add_row(item_row(query_item(32'h0)));
		// a single key is held for queries past it
		add_row(reg_row(CFG_KEY_COUNT, 32'd1));
		add_row(fixed_row(32'h7fff_ffff,
			result_t'{32'h0010_0000, 32'hfff0_0000, 32'h0, 1'b0}));
		add_row(item_row(query_item(32'h0000_1234)));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_REG) begin
				write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
			end else begin
				send_item(dir_rows[r].it, dir_rows[r].fixed, dir_rows[r].want);
			end
		end

		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			// first phase loads all slots so no later query reads an empty one
			case (phase)
				0: kc = KEY_SLOTS;
				1: kc = 127;
				2: kc = 0;
				default: begin
					case ($urandom_range(0, 9))
						0: kc = 0;
						1: kc = KEY_SLOTS;
						2: kc = $urandom_range(KEY_SLOTS + 1, 127);
						3: kc = 1;
						4: kc = 2;
						default: kc = $urandom_range(3, 12);
					endcase
				end
			endcase
			case ($urandom_range(0, 7))
				0: fr = 1;
				1: fr = 1000;
				2: fr = 1023;
				3: fr = 0;
				default: fr = $urandom_range(1, 1000);
			endcase
			idle_on = ($urandom_range(0, 3) != 0);
			write_reg(CFG_KEY_COUNT, 32'(kc));
			write_reg(CFG_FRAME_RATE, 32'(fr));
			write_reg(CFG_REST_X, rand_word());
			write_reg(CFG_REST_Y, rand_word());
			write_reg(CFG_REST_Z, rand_word());

			n_keys = (kc > KEY_SLOTS) ? KEY_SLOTS : kc;
			tprev = longint'($urandom_range(0, 32'h6_0000));
			case ($urandom_range(0, 3))
				0: begin
					smin = 0;
					smax = 256;
				end
				1: begin
					smin = 32'h8000;
					smax = 32'h4_0000;
				end
				2: begin
					smin = 1;
					smax = 32'((64'sh7fff_0000 - tprev) / ((n_keys > 0) ? n_keys : 1));
				end
				default: begin
					smin = 32'h1_0000;
					smax = 32'h1_0000;
				end
			endcase
			spread = (smax > 32'h1000_0000) ? 32'h1000_0000 : smax;

			for (i = 0; i < n_keys; i++) begin
				send_item(load_item(6'(i), tprev[30:0], rand_word(), rand_word(), rand_word()),
					1'b0, '0);
				random_items++;
				tprev += longint'($urandom_range(smin, smax));
			end

			nq = $urandom_range(20, 60);
			for (j = 0; j < nq; j++) begin
				if ($urandom_range(0, 7) == 0) begin
					// stray key, may break the ascending order
					send_item(load_item(6'($urandom), 31'($urandom), rand_word(), rand_word(),
						rand_word()), 1'b0, '0);
				end else begin
					case ($urandom_range(0, 9))
						0: qt = {1'b1, 31'($urandom)};
						1: qt = $urandom;
						2: qt = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h0;
						default: begin
							if (n_keys == 0 || trk_rate == 0) begin
								qt = $urandom_range(0, 32'hffff);
							end else begin
								// aim at or around a key of the track
								aim = longint'(key_tm[$urandom_range(0, n_keys - 1)]);
								if ($urandom_range(0, 3) != 0)
									aim += longint'($urandom_range(0, 2 * spread))
										- longint'(spread);
								qt_l = (aim - FRAME_ONE) / longint'(trk_rate);
								if (qt_l > Q_MAX) qt_l = Q_MAX;
								qt = qt_l[31:0];
							end
						end
					endcase
					send_item(query_item(qt), 1'b0, '0);
				end
				random_items++;
			end
			phase++;
		end

		settle();
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
